/* src/otwp_pkg.sv */
// Package: shared types and constants for the three-wire sensor poller.
package otwp_pkg;

    localparam int CNT_W     = 20;
    localparam int HALF_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    typedef enum logic [3:0] {
        PH_POWERUP   = 4'd0,
        PH_WR_RESET  = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_WR_MODE   = 4'd3,
        PH_POLL_WAIT = 4'd4,
        PH_RD_ADDR   = 4'd5,
        PH_RD_TURN   = 4'd6,
        PH_RD_DATA   = 4'd7
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_PERIOD = 3'd0,
        CFG_POWERUP     = 3'd1,
        CFG_RESET_WAIT  = 3'd2,
        CFG_POLL        = 3'd3,
        CFG_MODE        = 3'd4
    } cfg_index_t;

    localparam logic [7:0] CFG_REG    = 8'h06;
    localparam logic [7:0] STATUS_REG = 8'h02;
    localparam logic [7:0] X_REG      = 8'h03;
    localparam logic [7:0] Y_REG      = 8'h04;
    localparam logic [7:0] WRITE_BIT  = 8'h80;
    localparam logic [7:0] ADDR_MASK  = 8'h7F;
    localparam logic [7:0] RESET_CMD  = 8'h80;
    localparam logic [7:0] BAD_STATUS = 8'hFF;

    localparam logic [3:0] LAST_BIT_WORD = 4'd15;
    localparam logic [3:0] LAST_BIT_BYTE = 4'd7;

    localparam logic [HALF_W-1:0]    RST_HALF    = 10'd15;
    localparam logic [CNT_W-1:0]     RST_POWERUP = 20'd500000;
    localparam logic [CNT_W-1:0]     RST_RWAIT   = 20'd50000;
    localparam logic [CNT_W-1:0]     RST_POLL    = 20'd10000;
    localparam logic [7:0]           RST_MODE    = 8'd0;

endpackage

/* src/optical_sensor_three_wire_poller_unit.sv */
// Top level: tick-driven poller for a motion sensor on a clock and half-duplex data line.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------------
//  in      | in_valid / in_ready  | sdio_in
//  out     | out_valid / out_ready| clock_out data_out data_drive motion_valid delta_x delta_y
//  cfg     | cfg_valid / cfg_ready| cfg_index cfg_data
//
//  One tick per cycle unless the output stalls: the sequencer step sits between the
//  state registers and the output register, so a tick's result appears the next cycle.
//  A tick is taken while the output register is empty or being emptied in that cycle.
//  Reset puts the sequencer in its power-up wait and loads the register defaults.
//  Configuration writes are always taken and act at once.
module optical_sensor_three_wire_poller_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            sdio_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            clock_out,
    output logic                            data_out,
    output logic                            data_drive,
    output logic                            motion_valid,
    output logic signed [8:0]               delta_x,
    output logic signed [7:0]               delta_y,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [otwp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [otwp_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import otwp_pkg::*;

    logic [HALF_W-1:0] half_reg;
    logic [CNT_W-1:0]  powerup_reg;
    logic [CNT_W-1:0]  rwait_reg;
    logic [CNT_W-1:0]  poll_reg;
    logic [7:0]        mode_reg;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  tick_reg, tick_next;
    logic [3:0]        bit_reg, bit_next;
    logic [15:0]       shift_reg, shift_next;
    logic [7:0]        rbyte_reg, rbyte_next;
    logic [7:0]        rawx_reg, rawx_next;
    logic              clk_lvl_reg, clk_lvl_next;
    logic              drive_reg, drive_next;

    logic              ov_reg;
    logic              clock_out_reg, data_out_reg, data_drive_reg, motion_reg;
    logic signed [8:0] dx_reg;
    logic signed [7:0] dy_reg;

    logic              accept;
    logic [HALF_W-1:0] half_eff;
    logic [CNT_W-1:0]  tick_inc;
    logic              half_done;
    logic              valid_next;
    logic signed [8:0] dx_next;
    logic signed [7:0] dy_next;
    logic              dout_next;

    assign cfg_ready = 1'b1;
    assign in_ready  = !ov_reg || out_ready;
    assign accept    = in_valid && in_ready;

    assign half_eff  = (half_reg == '0) ? HALF_W'(1) : half_reg;
    assign tick_inc  = tick_reg + CNT_W'(1);
    assign half_done = tick_inc >= CNT_W'(half_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= RST_HALF;
            powerup_reg <= RST_POWERUP;
            rwait_reg   <= RST_RWAIT;
            poll_reg    <= RST_POLL;
            mode_reg    <= RST_MODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD: half_reg    <= cfg_data[HALF_W-1:0];
                CFG_POWERUP:     powerup_reg <= cfg_data[CNT_W-1:0];
                CFG_RESET_WAIT:  rwait_reg   <= cfg_data[CNT_W-1:0];
                CFG_POLL:        poll_reg    <= cfg_data[CNT_W-1:0];
                CFG_MODE:        mode_reg    <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        rbyte_next   = rbyte_reg;
        rawx_next    = rawx_reg;
        clk_lvl_next = clk_lvl_reg;
        drive_next   = drive_reg;
        valid_next   = 1'b0;
        dx_next      = '0;
        dy_next      = '0;

        unique case (phase_reg)
            PH_POWERUP, PH_RST_WAIT, PH_POLL_WAIT:
            begin
                if ((phase_reg == PH_POWERUP   && tick_reg >= powerup_reg) ||
                    (phase_reg == PH_RST_WAIT  && tick_reg >= rwait_reg)   ||
                    (phase_reg == PH_POLL_WAIT && tick_reg >= poll_reg))
                begin
                    tick_next    = '0;
                    bit_next     = '0;
                    clk_lvl_next = 1'b0;
                    drive_next   = 1'b1;
                    if (phase_reg == PH_POWERUP)
                    begin
                        phase_next = PH_WR_RESET;
                        shift_next = {CFG_REG | WRITE_BIT, RESET_CMD};
                    end
                    else if (phase_reg == PH_RST_WAIT)
                    begin
                        phase_next = PH_WR_MODE;
                        shift_next = {CFG_REG | WRITE_BIT, mode_reg};
                    end
                    else
                    begin
                        phase_next = PH_RD_ADDR;
                        shift_next = {STATUS_REG & ADDR_MASK, 8'h00};
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_WR_RESET, PH_WR_MODE, PH_RD_ADDR, PH_RD_DATA:
            begin
                if (!half_done)
                begin
                    tick_next = tick_inc;
                end
                else if (!clk_lvl_reg)
                begin
                    tick_next    = '0;
                    clk_lvl_next = 1'b1;
                    if (phase_reg == PH_RD_DATA)
                        rbyte_next = {rbyte_reg[6:0], sdio_in};
                end
                else if (bit_reg >= ((phase_reg == PH_WR_RESET || phase_reg == PH_WR_MODE)
                                     ? LAST_BIT_WORD : LAST_BIT_BYTE))
                begin
                    tick_next    = '0;
                    clk_lvl_next = 1'b1;
                    drive_next   = 1'b0;
                    phase_next   = PH_POLL_WAIT;
                    case (phase_reg)
                        PH_WR_RESET: phase_next = PH_RST_WAIT;
                        PH_WR_MODE:
                        begin
                            phase_next   = PH_RD_ADDR;
                            shift_next   = {STATUS_REG & ADDR_MASK, 8'h00};
                            bit_next     = '0;
                            clk_lvl_next = 1'b0;
                            drive_next   = 1'b1;
                        end
                        PH_RD_ADDR: phase_next = PH_RD_TURN;
                        default:
                        begin
                            if ((shift_reg[15:8] & ADDR_MASK) == STATUS_REG)
                            begin
                                if (rbyte_reg != BAD_STATUS && rbyte_reg[7])
                                begin
                                    phase_next   = PH_RD_ADDR;
                                    shift_next   = {X_REG & ADDR_MASK, 8'h00};
                                    bit_next     = '0;
                                    clk_lvl_next = 1'b0;
                                    drive_next   = 1'b1;
                                end
                            end
                            else if ((shift_reg[15:8] & ADDR_MASK) == X_REG)
                            begin
                                rawx_next    = rbyte_reg;
                                phase_next   = PH_RD_ADDR;
                                shift_next   = {Y_REG & ADDR_MASK, 8'h00};
                                bit_next     = '0;
                                clk_lvl_next = 1'b0;
                                drive_next   = 1'b1;
                            end
                            else if ((shift_reg[15:8] & ADDR_MASK) == Y_REG)
                            begin
                                valid_next = 1'b1;
                                dx_next    = -$signed({rbyte_reg[7], rbyte_reg});
                                dy_next    = $signed(rawx_reg);
                            end
                        end
                    endcase
                end
                else
                begin
                    tick_next    = '0;
                    bit_next     = bit_reg + 4'd1;
                    clk_lvl_next = 1'b0;
                end
            end
            PH_RD_TURN:
            begin
                tick_next = tick_inc;
                if (tick_inc >= CNT_W'({half_eff, 1'b0}))
                begin
                    phase_next   = PH_RD_DATA;
                    tick_next    = '0;
                    bit_next     = '0;
                    clk_lvl_next = 1'b0;
                    rbyte_next   = '0;
                end
            end
            default:
            begin
                phase_next   = PH_POLL_WAIT;
                tick_next    = '0;
                clk_lvl_next = 1'b1;
                drive_next   = 1'b0;
            end
        endcase

        dout_next = 1'b0;
        if (drive_next && (phase_next == PH_WR_RESET || phase_next == PH_WR_MODE ||
                           phase_next == PH_RD_ADDR))
            dout_next = shift_next[~bit_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_POWERUP;
            tick_reg    <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            rbyte_reg   <= '0;
            rawx_reg    <= '0;
            clk_lvl_reg <= 1'b1;
            drive_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            rbyte_reg   <= rbyte_next;
            rawx_reg    <= rawx_next;
            clk_lvl_reg <= clk_lvl_next;
            drive_reg   <= drive_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (accept)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            clock_out_reg  <= clk_lvl_next;
            data_out_reg   <= dout_next;
            data_drive_reg <= drive_next;
            motion_reg     <= valid_next;
            dx_reg         <= dx_next;
            dy_reg         <= dy_next;
        end
    end

    assign out_valid    = ov_reg;
    assign clock_out    = clock_out_reg;
    assign data_out     = data_out_reg;
    assign data_drive   = data_drive_reg;
    assign motion_valid = motion_reg;
    assign delta_x      = dx_reg;
    assign delta_y      = dy_reg;

endmodule

/* src/otwp_checker.sv */
// Checker: port-level assertions for the three-wire sensor poller, with its bind.
module otwp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic              clock_out,
    input logic              data_out,
    input logic              data_drive,
    input logic              motion_valid,
    input logic signed [8:0] delta_x,
    input logic signed [7:0] delta_y
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(motion_valid) &&
        $stable(delta_x) && $stable(delta_y) && $stable(clock_out))
        else $error("output transaction changed while stalled");

    a_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_drive |-> !data_out)
        else $error("data level shown on a released line");

    a_no_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !motion_valid |-> delta_x == 9'sd0 && delta_y == 8'sd0)
        else $error("deltas nonzero without a motion report");

    a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && motion_valid |-> clock_out && !data_drive)
        else $error("motion report outside the idle line state");

endmodule

bind optical_sensor_three_wire_poller_unit otwp_checker u_otwp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .clock_out    (clock_out),
    .data_out     (data_out),
    .data_drive   (data_drive),
    .motion_valid (motion_valid),
    .delta_x      (delta_x),
    .delta_y      (delta_y)
);

/* dv/tb_top.sv */
// Testbench for the three-wire sensor poller: every tick's pin state is predicted and checked.
module tb_top;
    import otwp_pkg::*;

    typedef struct packed {
        logic              sclk;
        logic              sdata;
        logic              sdrive;
        logic              report;
        logic signed [8:0] dx;
        logic signed [7:0] dy;
    } pin_state_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
        logic                 sdio;
        logic [4:0]           reps;
        logic                 has_exp;
        pin_state_t           exp;
    } stim_row_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [CFG_DAT_W-1:0] CFG_ALL_ONES = 20'hFFFFF;
    localparam logic [HALF_W-1:0]    HALF_MAX     = 10'd1023;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_TICKS    = 750;

    localparam pin_state_t PINS_IDLE        = '{1'b1, 1'b0, 1'b0, 1'b0, 9'sd0, 8'sd0};
    localparam pin_state_t PINS_WRITE_START = '{1'b0, 1'b1, 1'b1, 1'b0, 9'sd0, 8'sd0};
    localparam pin_state_t PINS_NONE        = '0;

    localparam stim_row_t DIRECTED [0:13] = '{
        '{ROW_TICK, CFG_HALF_PERIOD, 20'd0,        1'b0, 5'd1, 1'b1, PINS_IDLE},
        '{ROW_TICK, CFG_HALF_PERIOD, 20'd0,        1'b1, 5'd1, 1'b1, PINS_IDLE},
        '{ROW_CFG,  CFG_POWERUP,     CFG_ALL_ONES, 1'b0, 5'd0, 1'b0, PINS_NONE},
        '{ROW_TICK, CFG_HALF_PERIOD, 20'd0,        1'b0, 5'd1, 1'b1, PINS_IDLE},
        '{ROW_CFG,  CFG_HALF_PERIOD, 20'hFFC00,    1'b0, 5'd0, 1'b0, PINS_NONE},
        '{ROW_CFG,  CFG_MODE,        CFG_ALL_ONES, 1'b0, 5'd0, 1'b0, PINS_NONE},
        '{ROW_CFG,  CFG_RESET_WAIT,  20'd0,        1'b0, 5'd0, 1'b0, PINS_NONE},
        '{ROW_CFG,  CFG_POLL,        20'd0,        1'b0, 5'd0, 1'b0, PINS_NONE},
        '{ROW_CFG,  CFG_SPARE_LO,    20'h5A5A5,    1'b0, 5'd0, 1'b0, PINS_NONE},
        '{ROW_CFG,  CFG_SPARE_HI,    CFG_ALL_ONES, 1'b0, 5'd0, 1'b0, PINS_NONE},
        '{ROW_CFG,  CFG_POWERUP,     20'd0,        1'b0, 5'd0, 1'b0, PINS_NONE},
        '{ROW_TICK, CFG_HALF_PERIOD, 20'd0,        1'b1, 5'd1, 1'b1, PINS_WRITE_START},
        '{ROW_TICK, CFG_HALF_PERIOD, 20'd0,        1'b0, 5'd9, 1'b0, PINS_NONE},
        '{ROW_TICK, CFG_HALF_PERIOD, 20'd0,        1'b1, 5'd9, 1'b0, PINS_NONE}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 sdio_in = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 clock_out;
    logic                 data_out;
    logic                 data_drive;
    logic                 motion_valid;
    logic signed [8:0]    delta_x;
    logic signed [7:0]    delta_y;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    logic [HALF_W-1:0] p_half;
    logic [CNT_W-1:0]  p_powerup;
    logic [CNT_W-1:0]  p_rwait;
    logic [CNT_W-1:0]  p_poll;
    logic [7:0]        p_mode;
    phase_t            p_phase;
    logic [CNT_W-1:0]  p_count;
    logic [3:0]        p_bit;
    logic [15:0]       p_word;
    logic [7:0]        p_byte;
    logic [7:0]        p_held_x;
    logic              p_sclk;
    logic              p_drive;

    pin_state_t expected_pins [$];
    logic [7:0] sensor_byte = 8'h00;
    int mismatches = 0;
    int ticks_sent = 0;
    int hold_off_asked = 0;
    int hold_off_done = 0;

    optical_sensor_three_wire_poller_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sdio_in      (sdio_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .clock_out    (clock_out),
        .data_out     (data_out),
        .data_drive   (data_drive),
        .motion_valid (motion_valid),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void poller_reset();
        p_half    = RST_HALF;
        p_powerup = RST_POWERUP;
        p_rwait   = RST_RWAIT;
        p_poll    = RST_POLL;
        p_mode    = RST_MODE;
        p_phase   = PH_POWERUP;
        p_count   = '0;
        p_bit     = '0;
        p_word    = '0;
        p_byte    = '0;
        p_held_x  = '0;
        p_sclk    = 1'b1;
        p_drive   = 1'b0;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_HALF_PERIOD: p_half    = data[HALF_W-1:0];
            CFG_POWERUP:     p_powerup = data[CNT_W-1:0];
            CFG_RESET_WAIT:  p_rwait   = data[CNT_W-1:0];
            CFG_POLL:        p_poll    = data[CNT_W-1:0];
            CFG_MODE:        p_mode    = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic int unsigned half_len();
        return (p_half == '0) ? 1 : int'(p_half);
    endfunction

    function automatic void start_shift(phase_t ph, logic [15:0] word);
        p_phase = ph;
        p_word  = word;
        p_bit   = '0;
        p_count = '0;
        p_sclk  = 1'b0;
        p_drive = 1'b1;
    endfunction

    function automatic void go_idle(phase_t ph);
        p_phase = ph;
        p_count = '0;
        p_sclk  = 1'b1;
        p_drive = 1'b0;
    endfunction

    function automatic bit shift_step(logic [3:0] last, logic sd, bit capture);
        p_count = p_count + 1'b1;
        if (p_count < half_len())
            return 1'b0;
        p_count = '0;
        if (!p_sclk)
        begin
            p_sclk = 1'b1;
            if (capture)
                p_byte = {p_byte[6:0], sd};
            return 1'b0;
        end
        if (p_bit >= last)
            return 1'b1;
        p_bit  = p_bit + 1'b1;
        p_sclk = 1'b0;
        return 1'b0;
    endfunction

    function automatic bit wait_step(logic [CNT_W-1:0] lim);
        if (p_count >= lim)
            return 1'b1;
        p_count = p_count + 1'b1;
        return 1'b0;
    endfunction

    function automatic pin_state_t advance_poller(logic sd);
        pin_state_t pins;
        logic [7:0] addr;
        pins = '0;
        case (p_phase)
            PH_POWERUP:
                if (wait_step(p_powerup))
                    start_shift(PH_WR_RESET, {CFG_REG | WRITE_BIT, RESET_CMD});
            PH_WR_RESET:
                if (shift_step(LAST_BIT_WORD, sd, 1'b0))
                    go_idle(PH_RST_WAIT);
            PH_RST_WAIT:
                if (wait_step(p_rwait))
                    start_shift(PH_WR_MODE, {CFG_REG | WRITE_BIT, p_mode});
            PH_WR_MODE:
                if (shift_step(LAST_BIT_WORD, sd, 1'b0))
                    start_shift(PH_RD_ADDR, {STATUS_REG & ADDR_MASK, 8'h00});
            PH_POLL_WAIT:
                if (wait_step(p_poll))
                    start_shift(PH_RD_ADDR, {STATUS_REG & ADDR_MASK, 8'h00});
            PH_RD_ADDR:
                if (shift_step(LAST_BIT_BYTE, sd, 1'b0))
                    go_idle(PH_RD_TURN);
            PH_RD_TURN:
            begin
                p_count = p_count + 1'b1;
                if (p_count >= 2 * half_len())
                begin
                    p_phase = PH_RD_DATA;
                    p_count = '0;
                    p_bit   = '0;
                    p_sclk  = 1'b0;
                    p_byte  = '0;
                end
            end
            PH_RD_DATA:
                if (shift_step(LAST_BIT_BYTE, sd, 1'b1))
                begin
                    addr = p_word[15:8] & ADDR_MASK;
                    if (addr == STATUS_REG)
                    begin
                        if (p_byte != BAD_STATUS && p_byte[7])
                            start_shift(PH_RD_ADDR, {X_REG & ADDR_MASK, 8'h00});
                        else
                            go_idle(PH_POLL_WAIT);
                    end
                    else if (addr == X_REG)
                    begin
                        p_held_x = p_byte;
                        start_shift(PH_RD_ADDR, {Y_REG & ADDR_MASK, 8'h00});
                    end
                    else if (addr == Y_REG)
                    begin
                        pins.report = 1'b1;
                        pins.dx     = -$signed({p_byte[7], p_byte});
                        pins.dy     = p_held_x;
                        go_idle(PH_POLL_WAIT);
                    end
                    else
                        go_idle(PH_POLL_WAIT);
                end
            default:
                go_idle(PH_POLL_WAIT);
        endcase
        pins.sclk   = p_sclk;
        pins.sdrive = p_drive;
        if (p_drive && (p_phase == PH_WR_RESET || p_phase == PH_WR_MODE || p_phase == PH_RD_ADDR))
            pins.sdata = p_word[LAST_BIT_WORD - p_bit];
        return pins;
    endfunction

    // Model the sensor: one byte per read, served MSB first, with some line noise.
    function automatic logic pick_sdio();
        int r;
        r = $urandom_range(0, 99);
        if (p_phase == PH_RD_TURN && p_count == '0)
        begin
            if (p_word[15:8] == STATUS_REG)
            begin
                if (r < 10)
                    sensor_byte = BAD_STATUS;
                else if (r < 65)
                    sensor_byte = 8'h80 | 8'($urandom);
                else
                    sensor_byte = 8'($urandom);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: sensor_byte = 8'h80;
                    1: sensor_byte = 8'h7F;
                    2: sensor_byte = 8'hFF;
                    3: sensor_byte = 8'h00;
                    4: sensor_byte = 8'h01;
                    default: sensor_byte = 8'($urandom);
                endcase
            end
        end
        if (p_phase == PH_RD_DATA && r < 90)
            return sensor_byte[LAST_BIT_BYTE[2:0] - p_bit[2:0]];
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_tick(logic sd, bit typed, pin_state_t typed_pins);
        pin_state_t pins;
        in_valid <= 1'b1;
        sdio_in  <= sd;
        do
            @(posedge clk);
        while (!in_ready);
        pins = advance_poller(sd);
        expected_pins.push_back(typed ? typed_pins : pins);
        ticks_sent++;
    endtask

    task automatic sender_gap(bit burst);
        int g;
        g = burst ? 0 : gap_cycles();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_cfg(idx, data);
    endtask

    task automatic run_phase(int phase_no);
        logic [HALF_W-1:0]    half;
        logic [CNT_W-1:0]     rwait;
        logic [CNT_W-1:0]     poll;
        logic [7:0]           mode;
        logic [CFG_DAT_W-1:0] junk;
        bit                   extreme;
        bit                   burst;
        int                   r;
        int                   n;
        int                   sent;
        junk = CFG_DAT_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 35)
            half = '0;
        else if (r < 65)
            half = 10'd1;
        else if (r < 85)
            half = HALF_W'($urandom_range(2, 4));
        else if (r < 95)
            half = HALF_W'($urandom_range(5, 40));
        else
            half = HALF_MAX;
        r = $urandom_range(0, 99);
        if (r < 30)
            poll = '0;
        else if (r < 80)
            poll = CNT_W'($urandom_range(1, 30));
        else if (r < 92)
            poll = CNT_W'($urandom_range(31, 300));
        else
            poll = CFG_ALL_ONES;
        rwait = ($urandom_range(0, 9) == 0) ? CFG_ALL_ONES : CNT_W'($urandom_range(0, 40));
        r = $urandom_range(0, 9);
        mode = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
        extreme = (half == HALF_MAX) || (poll == CFG_ALL_ONES) || (rwait == CFG_ALL_ONES);
        n = extreme ? $urandom_range(20, 60) : $urandom_range(80, 300);
        burst = ($urandom_range(0, 3) == 0);

        settle();
        write_reg(CFG_HALF_PERIOD, {junk[CFG_DAT_W-1:HALF_W], half});
        write_reg(CFG_POWERUP, CNT_W'($urandom_range(0, 20'hFFFFF)));
        write_reg(CFG_RESET_WAIT, rwait);
        write_reg(CFG_POLL, poll);
        write_reg(CFG_MODE, {junk[CFG_DAT_W-1:8], mode});
        if ($urandom_range(0, 4) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), junk);
        cfg_valid <= 1'b0;

        // Keep offering while the output side is held off so the input backs up.
        if (phase_no == 1)
        begin
            burst = 1'b1;
            hold_off_asked++;
        end
        sent = 0;
        while (sent < n || hold_off_done != hold_off_asked)
        begin
            send_tick(pick_sdio(), 1'b0, PINS_NONE);
            sender_gap(burst);
            sent++;
        end
    endtask

    task automatic check_pin(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        pin_state_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pins.size() == 0)
            begin
                $error("transaction on output with nothing expected");
                mismatches++;
            end
            else
            begin
                want = expected_pins.pop_front();
                check_pin("clock_out", 32'(want.sclk), 32'(clock_out));
                check_pin("data_out", 32'(want.sdata), 32'(data_out));
                check_pin("data_drive", 32'(want.sdrive), 32'(data_drive));
                check_pin("motion_valid", 32'(want.report), 32'(motion_valid));
                check_pin("delta_x", 32'(want.dx), 32'(delta_x));
                check_pin("delta_y", 32'(want.dy), 32'(delta_y));
            end
        end
    end

    initial
    begin
        int run;
        int g;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_done != hold_off_asked)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done++;
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            g = gap_cycles();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    initial
    begin
        bit cfg_open;
        int start_ticks;
        int phase_no;
        poller_reset();
        cfg_open = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                if (!cfg_open)
                    settle();
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                repeat (DIRECTED[i].reps)
                begin
                    send_tick(DIRECTED[i].sdio, DIRECTED[i].has_exp, DIRECTED[i].exp);
                    sender_gap(1'b0);
                end
            end
        end

        start_ticks = ticks_sent;
        phase_no = 0;
        while (ticks_sent - start_ticks < RANDOM_TICKS)
        begin
            run_phase(phase_no);
            phase_no++;
        end
        settle();

        if (mismatches == 0)
            $display("optical_sensor_three_wire_poller_unit test passed");
        else
            $display("optical_sensor_three_wire_poller_unit test failed");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("optical_sensor_three_wire_poller_unit test failed");
        $finish;
    end

endmodule

/* sim.f */
src/otwp_pkg.sv
src/optical_sensor_three_wire_poller_unit.sv
src/otwp_checker.sv
dv/tb_top.sv
